### hdl/ida_pkg.sv
// Package for the identifier allocator: operation, status and sequencer state codes.
// No dependencies; used by id_allocator_deferred_release.
package ida_pkg;

   typedef enum logic [2:0] {
      MODE_ALLOC = 3'd0,
      MODE_MARK  = 3'd1,
      MODE_SWEEP = 3'd2,
      MODE_CLEAR = 3'd3,
      MODE_SET   = 3'd4,
      MODE_TEST  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_POP,
      S_MOD,
      S_SWEEP,
      S_DONE
   } state_type;

endpackage

### hdl/id_allocator_deferred_release.sv
// Identifier allocator with FIFO free list and deferred (swept) release.
// Depends on ida_pkg. Holds the free-list memory and the per-identifier state memory.
//
//   channel | direction | transaction
//   req_    | in        | mode, target_id, component_index, bit_value
//   rsp_    | out       | granted_id, status, bit_read, released_count
//
// Allocate steps through free-list read, state read, state write and result;
// mark, set and test skip the free-list read; rejected or unused modes only respond.
// Sweep and clear walk the state memory one identifier a cycle.
// After reset a clearing pass zeroes the state memory; req_ready is low meanwhile.
// The free list needs no pass: an entry not yet written reads as its own index.
// A new transaction is taken while the previous result waits in the output register.
module id_allocator_deferred_release #(
   parameter int ID_COUNT        = 256,
   parameter int COMPONENT_COUNT = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_target_id,
   input  logic [4:0] req_component_index,
   input  logic       req_bit_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_granted_id,
   output logic [1:0] rsp_status,
   output logic       rsp_bit_read,
   output logic [8:0] rsp_released_count
);

   localparam int IDW = $clog2(ID_COUNT);
   localparam int CW  = (COMPONENT_COUNT > 1) ? $clog2(COMPONENT_COUNT) : 1;
   localparam int SW  = COMPONENT_COUNT + 2;
   localparam int LIVE_BIT = COMPONENT_COUNT + 1;
   localparam int PEND_BIT = COMPONENT_COUNT;
   localparam logic [IDW+8:0] ID_LIMIT   = (IDW + 9)'(ID_COUNT);
   localparam logic [CW+5:0]  COMP_LIMIT = (CW + 6)'(COMPONENT_COUNT);
   localparam logic [IDW:0]   FILL_FULL  = (IDW + 1)'(ID_COUNT);
   localparam logic [IDW-1:0] ID_LAST    = IDW'(ID_COUNT - 1);

   // memories
   logic [SW-1:0]  st_mem [ID_COUNT];
   logic [IDW-1:0] q_mem  [ID_COUNT];

   ida_pkg::state_type  state_ff, state_in;
   logic [IDW-1:0]      idx_ff, idx_in;
   logic [IDW-1:0]      op_id_ff, op_id_in;
   ida_pkg::mode_type   mode_ff, mode_in;
   logic                bitv_ff, bitv_in;
   logic [CW-1:0]       comp_ff, comp_in;
   logic [IDW-1:0]      head_ff, head_in;
   logic [IDW-1:0]      tail_ff, tail_in;
   logic                wrapped_ff, wrapped_in;
   logic [IDW:0]        fill_ff, fill_in;
   logic [IDW:0]        count_ff, count_in;
   logic [7:0]          res_granted_ff, res_granted_in;
   ida_pkg::status_type res_status_ff, res_status_in;
   logic                res_bit_ff, res_bit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_granted_ff, rsp_granted_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_bit_ff, rsp_bit_in;
   logic [8:0]          rsp_count_ff, rsp_count_in;

   logic [SW-1:0]  st_rd_data_ff;
   logic [IDW-1:0] q_rd_data_ff;
   logic           q_written_ff;

   logic           st_wr_en;
   logic [IDW-1:0] st_wr_addr;
   logic [SW-1:0]  st_wr_data;
   logic [IDW-1:0] st_rd_addr;
   logic           q_wr_en;

   logic              accept;
   logic              out_free;
   logic [IDW+8:0]    target_ext;
   logic [CW+5:0]     comp_ext;
   logic              target_ok;
   logic              comp_ok;
   logic [IDW-1:0]    target_id;
   logic [IDW-1:0]    pop_id;
   logic [IDW+7:0]    pop_ext;
   logic [IDW+8:0]    count_ext;
   logic              release_hit;
   ida_pkg::mode_type req_mode_c;

   assign req_mode_c = ida_pkg::mode_type'(req_mode);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign target_ext = {{(IDW + 1){1'b0}}, req_target_id};
   assign comp_ext   = {{(CW + 1){1'b0}}, req_component_index};
   assign target_ok  = target_ext < ID_LIMIT;
   assign comp_ok    = comp_ext < COMP_LIMIT;
   assign target_id  = target_ext[IDW-1:0];
   assign pop_id     = q_written_ff ? q_rd_data_ff : head_ff;
   assign pop_ext    = {8'b0, pop_id};
   assign count_ext  = {8'b0, count_ff};
   assign release_hit = (mode_ff == ida_pkg::MODE_CLEAR) ? st_rd_data_ff[LIVE_BIT]
                                                         : st_rd_data_ff[PEND_BIT];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ida_pkg::S_INIT: begin
            if (idx_ff == ID_LAST) state_in = ida_pkg::S_IDLE;
         end
         ida_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_mode_c) inside
                  ida_pkg::MODE_ALLOC:
                     state_in = (fill_ff == '0) ? ida_pkg::S_DONE : ida_pkg::S_POP;
                  ida_pkg::MODE_MARK:
                     state_in = target_ok ? ida_pkg::S_MOD : ida_pkg::S_DONE;
                  ida_pkg::MODE_SWEEP, ida_pkg::MODE_CLEAR:
                     state_in = ida_pkg::S_SWEEP;
                  ida_pkg::MODE_SET, ida_pkg::MODE_TEST:
                     state_in = (target_ok && comp_ok) ? ida_pkg::S_MOD : ida_pkg::S_DONE;
                  default:
                     state_in = ida_pkg::S_DONE;
               endcase
            end
         end
         ida_pkg::S_POP:   state_in = ida_pkg::S_MOD;
         ida_pkg::S_MOD:   state_in = ida_pkg::S_DONE;
         ida_pkg::S_SWEEP: begin
            if (idx_ff == ID_LAST) state_in = ida_pkg::S_DONE;
         end
         ida_pkg::S_DONE: begin
            if (out_free) state_in = ida_pkg::S_IDLE;
         end
         default: state_in = ida_pkg::S_INIT;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready      = (state_ff == ida_pkg::S_IDLE);
      idx_in         = idx_ff;
      op_id_in       = op_id_ff;
      mode_in        = mode_ff;
      bitv_in        = bitv_ff;
      comp_in        = comp_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      wrapped_in     = wrapped_ff;
      fill_in        = fill_ff;
      count_in       = count_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      res_bit_in     = res_bit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_bit_in     = rsp_bit_ff;
      rsp_count_in   = rsp_count_ff;
      st_wr_en       = 1'b0;
      st_wr_addr     = op_id_ff;
      st_wr_data     = st_rd_data_ff;
      st_rd_addr     = op_id_ff;
      q_wr_en        = 1'b0;

      unique case (state_ff)
         ida_pkg::S_INIT: begin
            st_wr_en   = 1'b1;
            st_wr_addr = idx_ff;
            st_wr_data = '0;
            idx_in     = idx_ff + 1'b1;
         end
         ida_pkg::S_IDLE: begin
            st_rd_addr = target_id;
            if (accept) begin
               mode_in        = req_mode_c;
               bitv_in        = req_bit_value;
               comp_in        = comp_ext[CW-1:0];
               op_id_in       = target_id;
               idx_in         = '0;
               count_in       = '0;
               res_granted_in = '0;
               res_bit_in     = 1'b0;
               res_status_in  = ida_pkg::ST_OK;
               unique case (req_mode_c) inside
                  ida_pkg::MODE_ALLOC: begin
                     if (fill_ff == '0) res_status_in = ida_pkg::ST_EMPTY;
                  end
                  ida_pkg::MODE_MARK: begin
                     if (!target_ok) res_status_in = ida_pkg::ST_IGNORED;
                  end
                  ida_pkg::MODE_SWEEP, ida_pkg::MODE_CLEAR: begin
                     st_rd_addr = '0;
                  end
                  ida_pkg::MODE_SET, ida_pkg::MODE_TEST: begin
                     if (!(target_ok && comp_ok)) res_status_in = ida_pkg::ST_IGNORED;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ida_pkg::S_POP: begin
            st_rd_addr     = pop_id;
            op_id_in       = pop_id;
            res_granted_in = pop_ext[7:0];
            head_in        = (head_ff == ID_LAST) ? '0 : head_ff + 1'b1;
            fill_in        = fill_ff - 1'b1;
         end
         ida_pkg::S_MOD: begin
            case (mode_ff)
               ida_pkg::MODE_ALLOC: begin
                  st_wr_en             = 1'b1;
                  st_wr_data[LIVE_BIT] = 1'b1;
               end
               ida_pkg::MODE_MARK: begin
                  if (st_rd_data_ff[LIVE_BIT]) begin
                     st_wr_en             = 1'b1;
                     st_wr_data[PEND_BIT] = 1'b1;
                  end else begin
                     res_status_in = ida_pkg::ST_IGNORED;
                  end
               end
               ida_pkg::MODE_SET: begin
                  st_wr_en            = 1'b1;
                  st_wr_data[comp_ff] = bitv_ff;
               end
               default: begin
                  res_bit_in = st_rd_data_ff[comp_ff];
               end
            endcase
         end
         ida_pkg::S_SWEEP: begin
            st_rd_addr = idx_ff + 1'b1;
            st_wr_addr = idx_ff;
            idx_in     = idx_ff + 1'b1;
            if (release_hit) begin
               st_wr_en             = 1'b1;
               st_wr_data[LIVE_BIT] = 1'b0;
               st_wr_data[PEND_BIT] = 1'b0;
               count_in             = count_ff + 1'b1;
               if (fill_ff < FILL_FULL) begin
                  q_wr_en = 1'b1;
                  fill_in = fill_ff + 1'b1;
                  if (tail_ff == ID_LAST) begin
                     tail_in    = '0;
                     wrapped_in = 1'b1;
                  end else begin
                     tail_in = tail_ff + 1'b1;
                  end
               end
            end
         end
         ida_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_status_in  = res_status_ff;
               rsp_bit_in     = res_bit_ff;
               rsp_count_in   = count_ext[8:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ida_pkg::S_INIT;
         idx_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         wrapped_ff   <= 1'b0;
         fill_ff      <= FILL_FULL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wrapped_ff   <= wrapped_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_id_ff       <= op_id_in;
      mode_ff        <= mode_in;
      bitv_ff        <= bitv_in;
      comp_ff        <= comp_in;
      count_ff       <= count_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      res_bit_ff     <= res_bit_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_bit_ff     <= rsp_bit_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // state memory: {live, pending, component bits}
   always_ff @(posedge clock) begin
      if (st_wr_en) st_mem[st_wr_addr] <= st_wr_data;
      st_rd_data_ff <= st_mem[st_rd_addr];
   end

   // free list
   always_ff @(posedge clock) begin
      if (q_wr_en) q_mem[tail_ff] <= idx_ff;
      q_rd_data_ff <= q_mem[head_ff];
      q_written_ff <= wrapped_ff || (head_ff < tail_ff);
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_id     = rsp_granted_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_bit_read       = rsp_bit_ff;
   assign rsp_released_count = rsp_count_ff;

endmodule
